// File: rtl/scfe_pkg.sv
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types, codes and helpers for the SLCAN frame encoder.
// ----------------------------------------------------------------------------
package scfe_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic FUNC_HDR  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic [7:0] CH_T_LO = 8'h74;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_R_LO = 8'h72;
    localparam logic [7:0] CH_R_UP = 8'h52;
    localparam logic [7:0] CH_D_LO = 8'h64;
    localparam logic [7:0] CH_D_UP = 8'h44;

    typedef enum logic {
        K_HDR,
        K_DATA
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        ext;
        logic [7:0]  letter;
        logic [28:0] ident;
        logic [3:0]  dlc;
        logic [7:0]  data_byte;
        logic        last;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'b0, nib};
        end else begin
            c = 8'h37 + {4'b0, nib};
        end
        return c;
    endfunction

endpackage

// File: rtl/scfe_front.sv
// ----------------------------------------------------------------------------
// scfe_front
// Accepts input items, tracks expected payload bytes and queues encode jobs.
// ----------------------------------------------------------------------------
module scfe_front
    import scfe_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_full,
    input  logic        i_func,
    input  logic [28:0] i_frame_ident,
    input  logic        i_is_extended,
    input  logic        i_is_remote,
    input  logic        i_is_fd,
    input  logic [3:0]  i_length_code,
    input  logic [6:0]  i_byte_count,
    input  logic [7:0]  i_data_byte,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [6:0] MaxCnt = 7'(MAX_PAYLOAD);

    logic [6:0] r_rem;
    logic [6:0] n_rem;
    logic [6:0] cnt_sat;
    logic       accept;
    logic       is_hdr;

    assign accept = i_valid && !i_full;
    assign is_hdr = (i_func == FUNC_HDR);

    always_comb begin
        if (i_is_remote) begin
            cnt_sat = 7'd0;
        end else if (i_byte_count > MaxCnt) begin
            cnt_sat = MaxCnt;
        end else begin
            cnt_sat = i_byte_count;
        end
    end

    always_comb begin
        n_rem = r_rem;
        if (accept) begin
            if (is_hdr) begin
                n_rem = cnt_sat;
            end else if (r_rem != 7'd0) begin
                n_rem = r_rem - 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 7'd0;
        end else begin
            r_rem <= n_rem;
        end
    end

    assign o_push = accept && (is_hdr || (r_rem != 7'd0));

    always_comb begin
        o_job.kind      = is_hdr ? K_HDR : K_DATA;
        o_job.ext       = i_is_extended;
        o_job.ident     = i_is_extended ? i_frame_ident : {18'd0, i_frame_ident[10:0]};
        o_job.dlc       = i_length_code;
        o_job.data_byte = i_data_byte;
        o_job.last      = is_hdr ? (cnt_sat == 7'd0) : (r_rem == 7'd1);
        if (i_is_remote) begin
            o_job.letter = i_is_extended ? CH_R_UP : CH_R_LO;
        end else if (i_is_fd) begin
            o_job.letter = i_is_extended ? CH_D_UP : CH_D_LO;
        end else begin
            o_job.letter = i_is_extended ? CH_T_UP : CH_T_LO;
        end
    end

endmodule

// File: rtl/scfe_queue.sv
// ----------------------------------------------------------------------------
// scfe_queue
// Small job FIFO between the front and the character sequencer.
// ----------------------------------------------------------------------------
module scfe_queue
    import scfe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic [Q_AW:0]     n_cnt;

    assign o_full       = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

// File: rtl/scfe_back.sv
// ----------------------------------------------------------------------------
// scfe_back
// Character sequencer: expands one job into ASCII characters, one per cycle while i_stall is low.
// ----------------------------------------------------------------------------
module scfe_back
    import scfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_ascii_char,
    output logic       o_frame_end
);

    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic        r_valid;
    logic [7:0]  r_char;
    logic        r_end;
    logic        advance;
    logic [3:0]  ndig;
    logic [3:0]  last_idx;
    logic [3:0]  pos;
    logic [31:0] ident32;
    logic [7:0]  ch;
    logic        ch_end;
    logic        at_last;

    assign advance  = i_head_valid && (!r_valid || !i_stall);
    assign ndig     = i_head.ext ? 4'd8 : 4'd3;
    assign last_idx = (i_head.kind == K_HDR) ? (ndig + 4'd1) : 4'd1;
    assign at_last  = (r_idx == last_idx);
    assign pos      = ndig - r_idx;
    assign ident32  = {3'b0, i_head.ident};
    assign o_pop    = advance && at_last;

    always_comb begin
        ch_end = 1'b0;
        if (i_head.kind == K_HDR) begin
            if (r_idx == 4'd0) begin
                ch = i_head.letter;
            end else if (at_last) begin
                ch     = hex_char(i_head.dlc);
                ch_end = i_head.last;
            end else begin
                ch = hex_char(ident32[{pos[2:0], 2'b00} +: 4]);
            end
        end else begin
            if (r_idx == 4'd0) begin
                ch = hex_char(i_head.data_byte[7:4]);
            end else begin
                ch     = hex_char(i_head.data_byte[3:0]);
                ch_end = i_head.last;
            end
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (advance) begin
            n_idx = at_last ? 4'd0 : (r_idx + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (advance) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= ch;
            r_end  <= ch_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_frame_end  = r_end;

endmodule

// File: rtl/slcan_frame_encoder.sv
// ----------------------------------------------------------------------------
// slcan_frame_encoder
// Encodes CAN / CAN-FD frames (header + payload items) as SLCAN ASCII.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | i_valid / o_stall    | func, ident, flags, dlc, count, byte
//  out     | output    | o_valid / i_stall    | ascii_char, frame_end
//
// One character leaves per cycle while i_stall is low: a standard header makes 5
// characters, an extended header 10, a payload byte 2, set by the character sequencer in scfe_back.
// A 4-entry job queue lets the front accept items while the sequencer works.
// Dropped data items (no byte expected) are consumed at the input and queue no job.
// Synchronous active-low reset clears the byte count, queue and output valid.
// ----------------------------------------------------------------------------
module slcan_frame_encoder
    import scfe_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [28:0] i_frame_ident,
    input  logic        i_is_extended,
    input  logic        i_is_remote,
    input  logic        i_is_fd,
    input  logic [3:0]  i_length_code,
    input  logic [6:0]  i_byte_count,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_ascii_char,
    output logic        o_frame_end
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    t_job q_job;
    t_job q_head;

    assign o_stall = q_full;

    scfe_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_full        (q_full),
        .i_func        (i_func),
        .i_frame_ident (i_frame_ident),
        .i_is_extended (i_is_extended),
        .i_is_remote   (i_is_remote),
        .i_is_fd       (i_is_fd),
        .i_length_code (i_length_code),
        .i_byte_count  (i_byte_count),
        .i_data_byte   (i_data_byte),
        .o_push        (q_push),
        .o_job         (q_job)
    );

    scfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    scfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_frame_end  (o_frame_end)
    );

endmodule

// File: verif/tb_slcan_frame_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_slcan_frame_encoder
// Self-checking bench for the SLCAN ASCII frame encoder. Headers and payload
// bytes go in as bursts with random gaps while the output side stalls on its
// own pattern, with long hold-offs that back the block up. A scoreboard
// predicts every character and its end-of-frame flag and checks them in order.
// ----------------------------------------------------------------------------
module tb_slcan_frame_encoder;
    import scfe_pkg::*;

    localparam int MAX_PAYLOAD   = 64;
    localparam int RANDOM_ITEMS  = 350;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic        func;
        logic [28:0] ident;
        logic        ext;
        logic        rem;
        logic        fd;
        logic [3:0]  dlc;
        logic [6:0]  cnt;
        logic [7:0]  data;
    } t_enc_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    class frame_scoreboard;
        t_enc_char   expected_chars[$];
        int unsigned bytes_left;
        int unsigned errors;
        int unsigned checked;
        int unsigned frames;
        int unsigned payload_bytes;

        function new();
            bytes_left    = 0;
            errors        = 0;
            checked       = 0;
            frames        = 0;
            payload_bytes = 0;
        endfunction

        function logic [7:0] to_hex(logic [3:0] nib);
            return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h41 + 8'(nib) - 8'd10);
        endfunction

        function void push_char(logic [7:0] ch, logic last);
            t_enc_char c;
            c.ch   = ch;
            c.last = last;
            expected_chars.push_back(c);
        endfunction

        // returns the number of characters this transaction produces
        function int note_input(t_enc_item it);
            logic [7:0]  letter;
            logic [31:0] id;
            int          digits;
            int unsigned cnt;
            if (it.func == FUNC_HDR) begin
                if (it.rem) begin
                    letter = it.ext ? CH_R_UP : CH_R_LO;
                end else if (it.fd) begin
                    letter = it.ext ? CH_D_UP : CH_D_LO;
                end else begin
                    letter = it.ext ? CH_T_UP : CH_T_LO;
                end
                id     = it.ext ? {3'b0, it.ident} : {21'b0, it.ident[10:0]};
                digits = it.ext ? 8 : 3;
                cnt    = it.rem ? 0 : it.cnt;
                if (cnt > MAX_PAYLOAD) begin
                    cnt = MAX_PAYLOAD;
                end
                bytes_left = cnt;
                frames++;
                push_char(letter, 1'b0);
                for (int i = digits - 1; i >= 0; i--) begin
                    push_char(to_hex(id[4*i +: 4]), 1'b0);
                end
                push_char(to_hex(it.dlc), bytes_left == 0);
                return digits + 2;
            end
            if (bytes_left == 0) begin
                return 0;
            end
            bytes_left--;
            payload_bytes++;
            push_char(to_hex(it.data[7:4]), 1'b0);
            push_char(to_hex(it.data[3:0]), bytes_left == 0);
            return 2;
        endfunction

        function void check_result(logic [7:0] ch, logic last);
            t_enc_char e;
            if (expected_chars.size() == 0) begin
                $error("unexpected character %02h (frame_end %0b)", ch, last);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            checked++;
            if (ch !== e.ch) begin
                $error("ascii_char mismatch: expected %02h, got %02h", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("frame_end mismatch: expected %0b, got %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic        i_func        = FUNC_HDR;
    logic [28:0] i_frame_ident = '0;
    logic        i_is_extended = 1'b0;
    logic        i_is_remote   = 1'b0;
    logic        i_is_fd       = 1'b0;
    logic [3:0]  i_length_code = '0;
    logic [6:0]  i_byte_count  = '0;
    logic [7:0]  i_data_byte   = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [7:0]  o_ascii_char;
    logic        o_frame_end;

    frame_scoreboard sb = new();

    int unsigned cycles     = 0;
    int unsigned burst_left = 0;
    int unsigned sent       = 0;
    bit          long_hold  = 1'b0;

    slcan_frame_encoder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_frame_ident (i_frame_ident),
        .i_is_extended (i_is_extended),
        .i_is_remote   (i_is_remote),
        .i_is_fd       (i_is_fd),
        .i_length_code (i_length_code),
        .i_byte_count  (i_byte_count),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_ascii_char  (o_ascii_char),
        .o_frame_end   (o_frame_end)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_ascii_char, o_frame_end);
        end
    end

    // output side: random stall modes, plus long hold-offs on request
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= (cycles % 5 < 2);
                endcase
            end
        end
    end

    function automatic t_enc_item mk_hdr(logic [28:0] ident, logic ext, logic rem,
                                         logic fd, logic [3:0] dlc, logic [6:0] cnt);
        t_enc_item it;
        it.func  = FUNC_HDR;
        it.ident = ident;
        it.ext   = ext;
        it.rem   = rem;
        it.fd    = fd;
        it.dlc   = dlc;
        it.cnt   = cnt;
        it.data  = 8'($urandom);
        return it;
    endfunction

    function automatic t_enc_item mk_data(logic [7:0] b);
        t_enc_item it;
        it.func  = FUNC_DATA;
        it.ident = 29'($urandom);
        it.ext   = 1'($urandom);
        it.rem   = 1'($urandom);
        it.fd    = 1'($urandom);
        it.dlc   = 4'($urandom);
        it.cnt   = 7'($urandom);
        it.data  = b;
        return it;
    endfunction

    function automatic t_enc_item mk_noise();
        t_enc_item it;
        it      = mk_data(8'($urandom));
        it.func = 1'($urandom);
        return it;
    endfunction

    // call at a rising edge; returns at the edge that accepted the transaction
    task automatic send_item(input t_enc_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_func        <= it.func;
        i_frame_ident <= it.ident;
        i_is_extended <= it.ext;
        i_is_remote   <= it.rem;
        i_is_fd       <= it.fd;
        i_length_code <= it.dlc;
        i_byte_count  <= it.cnt;
        i_data_byte   <= it.data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
        void'(sb.note_input(it));
    endtask

    task automatic send_frame(input logic [6:0] cnt, input int unsigned n_data);
        send_item(mk_hdr(29'($urandom), 1'($urandom), ($urandom_range(0, 5) == 0),
                         1'($urandom), 4'($urandom), cnt));
        repeat (n_data) send_item(mk_data(8'($urandom)));
    endtask

    initial begin
        int unsigned r;
        int unsigned cnt;
        int unsigned k;
        int unsigned start;
        int unsigned holds;

        holds = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: masking, extremes, letter precedence, abandon, saturation
        send_item(mk_hdr(29'h1FFFF800, 1'b0, 1'b0, 1'b0, 4'h0, 7'd0));
        send_item(mk_hdr(29'h000007FF, 1'b0, 1'b0, 1'b0, 4'hF, 7'd1));
        send_item(mk_data(8'h00));
        send_item(mk_hdr(29'h1FFFFFFF, 1'b1, 1'b0, 1'b0, 4'h8, 7'd2));
        send_item(mk_data(8'hFF));
        send_item(mk_data(8'hA5));
        send_item(mk_hdr(29'h00000000, 1'b1, 1'b0, 1'b0, 4'hA, 7'd0));
        send_item(mk_hdr(29'h00000123, 1'b0, 1'b1, 1'b1, 4'h4, 7'd5));
        send_item(mk_hdr(29'h12345678, 1'b1, 1'b1, 1'b0, 4'hC, 7'd127));
        send_item(mk_data(8'h77));
        send_item(mk_hdr(29'h0ABCDE55, 1'b0, 1'b0, 1'b1, 4'h9, 7'd3));
        send_item(mk_data(8'h5A));
        send_item(mk_hdr(29'h15A5A5A5, 1'b1, 1'b0, 1'b1, 4'hF, 7'd127));
        send_item(mk_data(8'h3C));
        send_item(mk_data(8'hC3));
        send_item(mk_hdr(29'h0000029E, 1'b0, 1'b0, 1'b0, 4'h1, 7'd1));
        send_item(mk_data(8'h96));
        send_item(mk_data(8'h11));

        start = sent;
        while (sent < start + RANDOM_ITEMS) begin
            if ((holds == 0 && sent >= start + 100) ||
                (holds == 1 && sent >= start + 240)) begin
                long_hold = 1'b1;
                holds++;
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    cnt = $urandom_range(0, 8);
                end else if (k < 85) begin
                    cnt = $urandom_range(9, 24);
                end else if (k < 93) begin
                    cnt = $urandom_range(25, 64);
                end else begin
                    cnt = $urandom_range(65, 127);
                end
                send_frame(7'(cnt), (cnt > MAX_PAYLOAD) ? MAX_PAYLOAD : cnt);
                if ($urandom_range(0, 3) == 0) begin
                    send_item(mk_data(8'($urandom)));
                end
            end else if (r < 85) begin
                cnt = $urandom_range(2, 10);
                send_frame(7'(cnt), $urandom_range(0, cnt - 1));
            end else begin
                repeat ($urandom_range(1, 3)) send_item(mk_noise());
            end
        end
        i_valid <= 1'b0;

        for (k = 0; k < DRAIN_LIMIT && sb.pending() > 0; k++) begin
            @(posedge i_clk);
        end
        if (sb.pending() > 0) begin
            $error("%0d expected characters never arrived", sb.pending());
            sb.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions: %0d frames with %0d payload bytes; %0d chars checked.",
                 sent, sb.frames, sb.payload_bytes, sb.checked);
        $display("Output side held off %0d times for %0d cycles each; %0d errors.",
                 holds, LONG_HOLD, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: slcan_frame_encoder.f
rtl/scfe_pkg.sv
rtl/scfe_front.sv
rtl/scfe_queue.sv
rtl/scfe_back.sv
rtl/slcan_frame_encoder.sv
verif/tb_slcan_frame_encoder.sv
